[sv/fcpu_pkg.sv]
// Package for the fly camera pose update block: beat types, config and
// command structures, datapath operation codes and fixed-point constants.
// No dependencies.
package fcpu_pkg;

  localparam int TRIG_BITS_DEF = 16;

  localparam logic [16:0] FULL_TURN = 17'd92160;
  localparam logic [16:0] QUARTER   = 17'd23040;
  localparam logic [15:0] PITCH_LIM = 16'd22784;
  localparam logic [16:0] RAD_K     = 17'd73204;

  localparam logic [3:0] HS_SIN_FIRST = 4'd0;
  localparam logic [3:0] HS_SIN_LAST  = 4'd4;
  localparam logic [3:0] HS_COS_FIRST = 4'd5;
  localparam logic [3:0] HS_COS_LAST  = 4'd10;

  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_LOAD  = 5'd1;
  localparam logic [4:0] OP_MDX   = 5'd2;
  localparam logic [4:0] OP_YSUB  = 5'd3;
  localparam logic [4:0] OP_YRED  = 5'd4;
  localparam logic [4:0] OP_MDY   = 5'd5;
  localparam logic [4:0] OP_PITCH = 5'd6;
  localparam logic [4:0] OP_TQ    = 5'd7;
  localparam logic [4:0] OP_TX    = 5'd8;
  localparam logic [4:0] OP_TX2   = 5'd9;
  localparam logic [4:0] OP_TINIT = 5'd10;
  localparam logic [4:0] OP_HM    = 5'd11;
  localparam logic [4:0] OP_DLD   = 5'd12;
  localparam logic [4:0] OP_DIG   = 5'd13;
  localparam logic [4:0] OP_HT    = 5'd14;
  localparam logic [4:0] OP_SIN   = 5'd15;
  localparam logic [4:0] OP_SINR  = 5'd16;
  localparam logic [4:0] OP_COS   = 5'd17;
  localparam logic [4:0] OP_PM    = 5'd18;
  localparam logic [4:0] OP_PS    = 5'd19;
  localparam logic [4:0] OP_MM    = 5'd20;
  localparam logic [4:0] OP_MS    = 5'd21;
  localparam logic [4:0] OP_OUT   = 5'd22;

  typedef struct packed {
    logic [11:0] pointer_x;
    logic [11:0] pointer_y;
    logic        look_toggle;
    logic        preset_key;
    logic        move_fwd;
    logic        move_back;
    logic        move_right;
    logic        move_left;
    logic        move_up;
    logic        move_down;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] pitch_out;
    logic [16:0]        yaw_out;
    logic               look_on;
  } out_t;

  typedef struct packed {
    logic [15:0]        look_sensitivity;
    logic [23:0]        speed_step;
    logic signed [15:0] preset_pitch;
    logic [16:0]        preset_yaw;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
    logic       sel;
    logic [3:0] yk;
    logic [3:0] hs;
    logic [1:0] pi;
    logic [2:0] key;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  function automatic logic [7:0] horner_div(input logic [3:0] hs);
    logic [7:0] n;
    case (hs)
      4'd0: n = 8'd110;
      4'd1: n = 8'd72;
      4'd2: n = 8'd42;
      4'd3: n = 8'd20;
      4'd4: n = 8'd6;
      4'd5: n = 8'd132;
      4'd6: n = 8'd90;
      4'd7: n = 8'd56;
      4'd8: n = 8'd30;
      4'd9: n = 8'd12;
      default: n = 8'd2;
    endcase
    return n;
  endfunction

endpackage

[sv/fcpu_ctrl.sv]
// Sequencer of the fly camera pose update: steps one beat through the
// datapath operations. Depends on fcpu_pkg.
module fcpu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  fcpu_pkg::stat_t stat,
  output fcpu_pkg::cmd_t  cmd
);
  import fcpu_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_MDX   = 5'd1;
  localparam logic [4:0] ST_YSUB  = 5'd2;
  localparam logic [4:0] ST_YRED  = 5'd3;
  localparam logic [4:0] ST_MDY   = 5'd4;
  localparam logic [4:0] ST_PITCH = 5'd5;
  localparam logic [4:0] ST_TQ    = 5'd6;
  localparam logic [4:0] ST_TX    = 5'd7;
  localparam logic [4:0] ST_TX2   = 5'd8;
  localparam logic [4:0] ST_TINIT = 5'd9;
  localparam logic [4:0] ST_HM    = 5'd10;
  localparam logic [4:0] ST_DLD   = 5'd11;
  localparam logic [4:0] ST_DIG   = 5'd12;
  localparam logic [4:0] ST_HT    = 5'd13;
  localparam logic [4:0] ST_SIN   = 5'd14;
  localparam logic [4:0] ST_SINR  = 5'd15;
  localparam logic [4:0] ST_COS   = 5'd16;
  localparam logic [4:0] ST_PM    = 5'd17;
  localparam logic [4:0] ST_PS    = 5'd18;
  localparam logic [4:0] ST_MM    = 5'd19;
  localparam logic [4:0] ST_MS    = 5'd20;
  localparam logic [4:0] ST_OUT   = 5'd21;

  logic [4:0] state;
  logic [3:0] yk;
  logic [3:0] hs;
  logic [2:0] dc;
  logic       sel;
  logic [1:0] pi;
  logic [2:0] mj;
  logic [1:0] mi;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd.sel  = sel;
    cmd.yk   = yk;
    cmd.hs   = hs;
    cmd.pi   = pi;
    cmd.key  = mj;
    cmd.comp = mi;
    case (state)
      ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NOP;
      ST_MDX:   cmd.op = OP_MDX;
      ST_YSUB:  cmd.op = OP_YSUB;
      ST_YRED:  cmd.op = OP_YRED;
      ST_MDY:   cmd.op = OP_MDY;
      ST_PITCH: cmd.op = OP_PITCH;
      ST_TQ:    cmd.op = OP_TQ;
      ST_TX:    cmd.op = OP_TX;
      ST_TX2:   cmd.op = OP_TX2;
      ST_TINIT: cmd.op = OP_TINIT;
      ST_HM:    cmd.op = OP_HM;
      ST_DLD:   cmd.op = OP_DLD;
      ST_DIG:   cmd.op = OP_DIG;
      ST_HT:    cmd.op = OP_HT;
      ST_SIN:   cmd.op = OP_SIN;
      ST_SINR:  cmd.op = OP_SINR;
      ST_COS:   cmd.op = OP_COS;
      ST_PM:    cmd.op = OP_PM;
      ST_PS:    cmd.op = OP_PS;
      ST_MM:    cmd.op = OP_MM;
      ST_MS:    cmd.op = OP_MS;
      ST_OUT:   cmd.op = stat.busy ? OP_NOP : OP_OUT;
      default:  cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      yk    <= '0;
      hs    <= '0;
      dc    <= '0;
      sel   <= 1'b0;
      pi    <= '0;
      mj    <= '0;
      mi    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_MDX;
        end
        ST_MDX:  state <= ST_YSUB;
        ST_YSUB: begin
          yk    <= 4'd12;
          state <= ST_YRED;
        end
        ST_YRED: begin
          if (yk == 4'd0) state <= ST_MDY;
          else yk <= yk - 4'd1;
        end
        ST_MDY: state <= ST_PITCH;
        ST_PITCH: begin
          sel   <= 1'b0;
          state <= ST_TQ;
        end
        ST_TQ: state <= ST_TX;
        ST_TX: state <= ST_TX2;
        ST_TX2: begin
          hs    <= HS_SIN_FIRST;
          state <= ST_TINIT;
        end
        ST_TINIT: state <= ST_HM;
        ST_HM:    state <= ST_DLD;
        ST_DLD: begin
          dc    <= '0;
          state <= ST_DIG;
        end
        ST_DIG: begin
          dc <= dc + 3'd1;
          if (dc == 3'd7) state <= ST_HT;
        end
        ST_HT: begin
          if (hs == HS_SIN_LAST) state <= ST_SIN;
          else if (hs == HS_COS_LAST) state <= ST_COS;
          else begin
            hs    <= hs + 4'd1;
            state <= ST_HM;
          end
        end
        ST_SIN: state <= ST_SINR;
        ST_SINR: begin
          hs    <= HS_COS_FIRST;
          state <= ST_TINIT;
        end
        ST_COS: begin
          if (!sel) begin
            sel   <= 1'b1;
            state <= ST_TQ;
          end else begin
            pi    <= '0;
            state <= ST_PM;
          end
        end
        ST_PM: state <= ST_PS;
        ST_PS: begin
          if (pi == 2'd3) begin
            mj    <= '0;
            mi    <= '0;
            state <= ST_MM;
          end else begin
            pi    <= pi + 2'd1;
            state <= ST_PM;
          end
        end
        ST_MM: state <= ST_MS;
        ST_MS: begin
          if (mi == 2'd2) begin
            mi <= '0;
            if (mj == 3'd5) state <= ST_OUT;
            else begin
              mj    <= mj + 3'd1;
              state <= ST_MM;
            end
          end else begin
            mi    <= mi + 2'd1;
            state <= ST_MM;
          end
        end
        ST_OUT: begin
          if (!stat.busy) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/fcpu_dp.sv]
// Datapath of the fly camera pose update: pose state, shared multiplier,
// radix-16 constant divider, trig chain and output register. Depends on fcpu_pkg.
module fcpu_dp #(
  parameter int TRIG_BITS = fcpu_pkg::TRIG_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  fcpu_pkg::cmd_t  cmd,
  input  fcpu_pkg::cfg_t  cfg,
  input  fcpu_pkg::in_t   in_data,
  input  logic            out_stall,
  output fcpu_pkg::stat_t stat,
  output logic            out_valid,
  output fcpu_pkg::out_t  out_data
);
  import fcpu_pkg::*;

  localparam int F  = TRIG_BITS - 1;
  localparam int SH = 31 - TRIG_BITS;
  localparam logic [32:0] TRIG_MAX = (33'd1 << F) - 33'd1;
  localparam logic signed [64:0] RND = 65'sd1 <<< (F - 1);
  localparam logic [31:0] ONE30 = 32'h4000_0000;

  logic [11:0]               prev_x;
  logic [11:0]               prev_y;
  logic                      look;
  logic signed [15:0]        pitch;
  logic [16:0]               yaw;
  logic signed [31:0]        pos [3];

  in_t                       in_reg;
  logic signed [12:0]        dx;
  logic signed [12:0]        dy;
  logic signed [64:0]        prod;
  logic [28:0]               ymag;
  logic                      yneg;
  logic [1:0]                tq;
  logic [14:0]               tr;
  logic [30:0]               x;
  logic [31:0]               x2;
  logic [30:0]               t;
  logic [7:0]                drem;
  logic [31:0]               dq;
  logic [31:0]               dnum;
  logic signed [TRIG_BITS-1:0] s_raw;
  logic signed [TRIG_BITS-1:0] sp, cp, sy, cy;
  logic signed [TRIG_BITS-1:0] f0, f2, u0, u2;

  logic signed [32:0]        ma;
  logic signed [31:0]        mb;
  logic signed [TRIG_BITS-1:0] pa, pb, dir;
  logic [16:0]               ang;
  logic [1:0]                qn;
  logic [14:0]               rn;
  logic [11:0]               part;
  logic [7:0]                dn;
  logic [3:0]                dig;
  logic signed [64:0]        rnd;
  logic signed [31:0]        vy;
  logic signed [31:0]        vp;
  logic [29:0]               ycmp;
  logic signed [TRIG_BITS-1:0] c_raw;
  logic signed [TRIG_BITS-1:0] s_q, c_q;
  logic signed [33:0]        pnew;
  logic [5:0]                keys;

  function automatic logic signed [TRIG_BITS-1:0] to_trig(input logic [31:0] q30);
    logic [32:0] v;
    v = ({1'b0, q30} + (33'd1 << (SH - 1))) >> SH;
    if (v > TRIG_MAX) v = TRIG_MAX;
    return v[TRIG_BITS-1:0];
  endfunction

  function automatic logic signed [15:0] clamp_p(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd22784) r = $signed(PITCH_LIM);
    else if (v < -32'sd22784) r = -$signed(PITCH_LIM);
    else r = v[15:0];
    return r;
  endfunction

  assign stat.busy = out_valid & out_stall;
  assign keys = {in_reg.move_down, in_reg.move_up, in_reg.move_left,
                 in_reg.move_right, in_reg.move_back, in_reg.move_fwd};

  always_comb begin
    pa = cp;
    pb = sy;
    case (cmd.pi)
      2'd0: begin pa = cp; pb = sy; end
      2'd1: begin pa = cp; pb = cy; end
      2'd2: begin pa = sp; pb = sy; end
      default: begin pa = sp; pb = cy; end
    endcase
    dir = '0;
    case (cmd.key[2:1])
      2'd0: begin
        case (cmd.comp)
          2'd0: dir = f0;
          2'd1: dir = sp;
          default: dir = f2;
        endcase
      end
      2'd1: begin
        case (cmd.comp)
          2'd0: dir = -cy;
          2'd1: dir = '0;
          default: dir = sy;
        endcase
      end
      default: begin
        case (cmd.comp)
          2'd0: dir = u0;
          2'd1: dir = cp;
          default: dir = u2;
        endcase
      end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MDX: begin ma = 33'(dx); mb = $signed({16'b0, cfg.look_sensitivity}); end
      OP_MDY: begin ma = 33'(dy); mb = $signed({16'b0, cfg.look_sensitivity}); end
      OP_TX:  begin ma = $signed({18'b0, tr}); mb = $signed({15'b0, RAD_K}); end
      OP_TX2: begin ma = $signed({2'b0, prod[30:0]}); mb = $signed({1'b0, prod[30:0]}); end
      OP_HM:  begin ma = $signed({1'b0, x2}); mb = $signed({1'b0, t}); end
      OP_SIN: begin ma = $signed({2'b0, x}); mb = $signed({1'b0, t}); end
      OP_PM:  begin ma = 33'(pa); mb = 32'(pb); end
      OP_MM:  begin ma = $signed({9'b0, cfg.speed_step}); mb = 32'(dir); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    if (cmd.sel) ang = yaw;
    else if (pitch < 0) ang = 17'(pitch) + FULL_TURN;
    else ang = 17'(pitch);
    if (ang >= 17'd69120) qn = 2'd3;
    else if (ang >= 17'd46080) qn = 2'd2;
    else if (ang >= QUARTER) qn = 2'd1;
    else qn = 2'd0;
    rn = 15'(ang - 17'(qn * QUARTER));

    dn   = horner_div(cmd.hs);
    part = {drem, dnum[31:28]};
    dig  = '0;
    for (int k = 1; k < 16; k++) begin
      if (part >= 12'(k * dn)) dig = 4'(k);
    end

    rnd  = (prod + RND) >>> F;
    vy   = $signed({15'b0, yaw}) - $signed(prod[31:0]);
    vp   = 32'(pitch) - $signed(prod[31:0]);
    ycmp = 30'(FULL_TURN) << cmd.yk;

    c_raw = to_trig({1'b0, t});
    case (tq)
      2'd0: begin s_q = s_raw;  c_q = c_raw;  end
      2'd1: begin s_q = c_raw;  c_q = -s_raw; end
      2'd2: begin s_q = -s_raw; c_q = -c_raw; end
      default: begin s_q = -c_raw; c_q = s_raw; end
    endcase

    if (cmd.key[0]) pnew = 34'(pos[cmd.comp]) - rnd[33:0];
    else pnew = 34'(pos[cmd.comp]) + rnd[33:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      look      <= 1'b0;
      pitch     <= '0;
      yaw       <= '0;
      pos[0]    <= '0;
      pos[1]    <= '0;
      pos[2]    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          prev_x <= in_data.pointer_x;
          prev_y <= in_data.pointer_y;
          look   <= look ^ in_data.look_toggle;
        end
        OP_MDY: begin
          if (look) begin
            if (yneg && ymag != '0) yaw <= 17'(29'(FULL_TURN) - ymag);
            else yaw <= ymag[16:0];
          end
        end
        OP_PITCH: begin
          if (in_reg.preset_key) begin
            pitch <= clamp_p(32'(cfg.preset_pitch));
            if (cfg.preset_yaw >= FULL_TURN) yaw <= cfg.preset_yaw - FULL_TURN;
            else yaw <= cfg.preset_yaw;
          end else if (look) begin
            pitch <= clamp_p(vp);
          end
        end
        OP_MS: begin
          if (keys[cmd.key]) begin
            if (pnew > 34'sd2147483647) pos[cmd.comp] <= 32'sh7FFF_FFFF;
            else if (pnew < -34'sd2147483648) pos[cmd.comp] <= 32'sh8000_0000;
            else pos[cmd.comp] <= pnew[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_reg <= in_data;
        dx     <= $signed({1'b0, in_data.pointer_x}) - $signed({1'b0, prev_x});
        dy     <= $signed({1'b0, in_data.pointer_y}) - $signed({1'b0, prev_y});
      end
      OP_MDX, OP_MDY, OP_TX, OP_TX2, OP_HM, OP_SIN, OP_PM, OP_MM: prod <= ma * mb;
      OP_YSUB: begin
        ymag <= vy[31] ? 29'(-vy) : 29'(vy);
        yneg <= vy[31];
      end
      OP_YRED: begin
        if ({1'b0, ymag} >= ycmp) ymag <= ymag - ycmp[28:0];
      end
      OP_TQ: begin
        tq <= qn;
        tr <= rn;
      end
      OP_TINIT: begin
        t <= ONE30[30:0];
        if (cmd.hs == HS_SIN_FIRST) x2 <= prod[61:30];
      end
      OP_DLD: begin
        dnum <= prod[61:30];
        drem <= '0;
        dq   <= '0;
      end
      OP_DIG: begin
        drem <= 8'(part - 12'({8'b0, dig} * {4'b0, dn}));
        dq   <= {dq[27:0], dig};
        dnum <= {dnum[27:0], 4'b0};
      end
      OP_HT: t <= (dq >= ONE30) ? '0 : 31'(ONE30 - dq);
      OP_SINR: s_raw <= to_trig(prod[61:30]);
      OP_COS: begin
        if (cmd.sel) begin
          sy <= s_q;
          cy <= c_q;
        end else begin
          sp <= s_q;
          cp <= c_q;
        end
      end
      OP_PS: begin
        case (cmd.pi)
          2'd0: f0 <= rnd[TRIG_BITS-1:0];
          2'd1: f2 <= rnd[TRIG_BITS-1:0];
          2'd2: u0 <= -rnd[TRIG_BITS-1:0];
          default: u2 <= -rnd[TRIG_BITS-1:0];
        endcase
      end
      OP_OUT: begin
        out_data.pos_x     <= pos[0];
        out_data.pos_y     <= pos[1];
        out_data.pos_z     <= pos[2];
        out_data.pitch_out <= pitch;
        out_data.yaw_out   <= yaw;
        out_data.look_on   <= look;
      end
      default: ;
    endcase
    if (cmd.op == OP_TX2) begin
      x <= prod[30:0];
    end
  end

endmodule

[sv/fly_camera_pose_update.sv]
// Top level of the fly camera pose update: APB configuration registers,
// sequencer and datapath. Depends on fcpu_pkg, fcpu_ctrl and fcpu_dp.
//
// One input beat per frame tick carries the absolute pointer position and
// the key flags; one output beat returns position, pitch, yaw and look flag.
// Both channels use valid and stall. An input beat is taken only while the
// sequencer is idle; in_stall is high for the whole update.
// An update lasts from the edge that takes the input beat to the first
// cycle with out_valid high: most of it is the two sine/cosine
// evaluations, eleven Horner steps each, every step one shared multiply and
// an eight-digit radix-16 division by a small constant. The next input beat
// can be taken the cycle after the output register is loaded, even while
// out_stall holds the result. If the receiver stalls and the output register
// is still full when the next result is ready, the sequencer waits until
// the register frees. Reset clears the pose, the stored pointer and the
// look flag, loads the register defaults and drops out_valid. Configuration
// is written through the APB port; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module fly_camera_pose_update #(
  parameter int TRIG_BITS = fcpu_pkg::TRIG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  fcpu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fcpu_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import fcpu_pkg::*;

  localparam logic [1:0] REG_SENS   = 2'd0;
  localparam logic [1:0] REG_SPEED  = 2'd1;
  localparam logic [1:0] REG_PPITCH = 2'd2;
  localparam logic [1:0] REG_PYAW   = 2'd3;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.look_sensitivity <= 16'd256;
      cfg.speed_step       <= 24'd65536;
      cfg.preset_pitch     <= '0;
      cfg.preset_yaw       <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SENS:   cfg.look_sensitivity <= pwdata[15:0];
        REG_SPEED:  cfg.speed_step       <= pwdata[23:0];
        REG_PPITCH: cfg.preset_pitch     <= pwdata[15:0];
        REG_PYAW:   cfg.preset_yaw       <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SENS:   prdata = {16'b0, cfg.look_sensitivity};
      REG_SPEED:  prdata = {8'b0, cfg.speed_step};
      REG_PPITCH: prdata = {16'b0, cfg.preset_pitch};
      REG_PYAW:   prdata = {15'b0, cfg.preset_yaw};
      default:    prdata = '0;
    endcase
  end

  fcpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcpu_dp #(
    .TRIG_BITS (TRIG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/fly_camera_pose_update_tb.sv]
// Testbench for fly_camera_pose_update: drives pointer and key beats, writes
// the APB registers between phases and checks every pose beat against an
// in-bench fixed-point model. Depends on fcpu_pkg and the block's RTL.
module fly_camera_pose_update_tb;
  import fcpu_pkg::*;

  localparam int FRAC = TRIG_BITS_DEF - 1;
  localparam logic [3:0] REG_SENS = 4'd0;
  localparam logic [3:0] REG_SPEED = 4'd4;
  localparam logic [3:0] REG_PPITCH = 4'd8;
  localparam logic [3:0] REG_PYAW = 4'd12;
  localparam logic [3:0] REG_BEYOND = 4'd0;

  class pose_tracker;
    logic [15:0] sens;
    logic [23:0] speed;
    logic signed [15:0] pre_pitch;
    logic [16:0] pre_yaw;
    logic [11:0] last_px, last_py;
    bit looking;
    longint pitch, yaw;
    longint pos[3];
    out_t pending[$];
    int errors, checked;

    function new();
      sens = 256; speed = 65536; pre_pitch = 0; pre_yaw = 0;
      last_px = 0; last_py = 0; looking = 0; pitch = 0; yaw = 0;
      pos[0] = 0; pos[1] = 0; pos[2] = 0; errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [31:0] v);
      case ({addr[3:2], 2'b00})
        REG_SENS: sens = v[15:0];
        REG_SPEED: speed = v[23:0];
        REG_PPITCH: pre_pitch = v[15:0];
        REG_PYAW: pre_yaw = v[16:0];
        default: ;
      endcase
    endfunction

    function longint fshift(longint v, int n);
      return v >>> n;
    endfunction

    function longint rshift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint hstep(longint x2, longint t, longint n);
      longint sub;
      sub = ((x2 * t) >> 30) / n;
      return sub >= (longint'(1) << 30) ? 0 : (longint'(1) << 30) - sub;
    endfunction

    function longint q1(longint q30);
      longint v, mx;
      mx = (longint'(1) << FRAC) - 1;
      v = (q30 + (longint'(1) << (29 - FRAC))) >> (30 - FRAC);
      return v > mx ? mx : v;
    endfunction

    function void sincos(longint ang, output longint so, output longint co);
      longint a, r, x, x2, t, s, c;
      int q;
      a = ang % 92160;
      if (a < 0) a += 92160;
      q = int'(a / 23040);
      r = a % 23040;
      x = r * 73204;
      x2 = (x * x) >> 30;
      t = longint'(1) << 30;
      t = hstep(x2, t, 110); t = hstep(x2, t, 72); t = hstep(x2, t, 42);
      t = hstep(x2, t, 20); t = hstep(x2, t, 6);
      s = q1((x * t) >> 30);
      t = longint'(1) << 30;
      t = hstep(x2, t, 132); t = hstep(x2, t, 90); t = hstep(x2, t, 56);
      t = hstep(x2, t, 30); t = hstep(x2, t, 12); t = hstep(x2, t, 2);
      c = q1(t);
      case (q)
        0: begin so = s; co = c; end
        1: begin so = c; co = -s; end
        2: begin so = -s; co = -c; end
        default: begin so = -c; co = s; end
      endcase
    endfunction

    function longint clampp(longint p);
      if (p > 22784) return 22784;
      if (p < -22784) return -22784;
      return p;
    endfunction

    function void step_along(longint d0, longint d1, longint d2, bit neg);
      longint dir[3], d, p;
      dir[0] = d0; dir[1] = d1; dir[2] = d2;
      for (int i = 0; i < 3; i++) begin
        d = rshift(longint'(speed) * dir[i], FRAC);
        p = pos[i] + (neg ? -d : d);
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        pos[i] = p;
      end
    endfunction

    function void note_input(in_t b);
      longint dx, dy, sp, cp, sy, cy, f0, f2, u0, u2;
      out_t e;
      dx = longint'(b.pointer_x) - longint'(last_px);
      dy = longint'(b.pointer_y) - longint'(last_py);
      last_px = b.pointer_x; last_py = b.pointer_y;
      if (b.look_toggle) looking = !looking;
      if (looking) begin
        yaw = (yaw - dx * longint'(sens)) % 92160;
        if (yaw < 0) yaw += 92160;
        pitch = clampp(pitch - dy * longint'(sens));
      end
      if (b.preset_key) begin
        pitch = clampp(pre_pitch);
        yaw = longint'(pre_yaw) % 92160;
      end
      sincos(pitch, sp, cp);
      sincos(yaw, sy, cy);
      f0 = rshift(cp * sy, FRAC); f2 = rshift(cp * cy, FRAC);
      u0 = -rshift(sp * sy, FRAC); u2 = -rshift(sp * cy, FRAC);
      if (b.move_fwd) step_along(f0, sp, f2, 0);
      if (b.move_back) step_along(f0, sp, f2, 1);
      if (b.move_right) step_along(-cy, 0, sy, 0);
      if (b.move_left) step_along(-cy, 0, sy, 1);
      if (b.move_up) step_along(u0, cp, u2, 0);
      if (b.move_down) step_along(u0, cp, u2, 1);
      e.pos_x = 32'(pos[0]); e.pos_y = 32'(pos[1]); e.pos_z = 32'(pos[2]);
      e.pitch_out = 16'(pitch); e.yaw_out = 17'(yaw); e.look_on = looking;
      pending.push_back(e);
    endfunction

    function void check_result(out_t a);
      out_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("pose beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.pos_x !== e.pos_x) begin
        $error("pos_x expected %0d actual %0d", e.pos_x, a.pos_x); errors++;
      end
      if (a.pos_y !== e.pos_y) begin
        $error("pos_y expected %0d actual %0d", e.pos_y, a.pos_y); errors++;
      end
      if (a.pos_z !== e.pos_z) begin
        $error("pos_z expected %0d actual %0d", e.pos_z, a.pos_z); errors++;
      end
      if (a.pitch_out !== e.pitch_out) begin
        $error("pitch_out expected %0d actual %0d", e.pitch_out, a.pitch_out); errors++;
      end
      if (a.yaw_out !== e.yaw_out) begin
        $error("yaw_out expected %0d actual %0d", e.yaw_out, a.yaw_out); errors++;
      end
      if (a.look_on !== e.look_on) begin
        $error("look_on expected %0d actual %0d", e.look_on, a.look_on); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  in_t in_data = '0;
  out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int idle_pct = 30;
  int sent = 0;
  pose_tracker tracker;

  fly_camera_pose_update DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_data);
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic apb_write(logic [3:0] addr, logic [31:0] v);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= v; penable <= 0;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    tracker.write_reg(addr, v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_beat(in_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1; in_data <= b;
    do @(posedge clk); while (in_stall);
    tracker.note_input(b);
    sent++;
  endtask

  function automatic in_t rand_beat(bit smooth);
    in_t b;
    b = in_t'($urandom);
    b.pointer_x = 12'($urandom);
    b.pointer_y = 12'($urandom);
    if (smooth) begin
      b.pointer_x = 12'(tracker.last_px + $urandom_range(40) - 20);
      b.pointer_y = 12'(tracker.last_py + $urandom_range(40) - 20);
      b.look_toggle = ($urandom_range(15) == 0);
      b.preset_key = ($urandom_range(15) == 0);
    end
    return b;
  endfunction

  initial begin
    in_t b;
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    b = '0; b.pointer_x = 12'hFFF; b.pointer_y = 12'hFFF; b.move_fwd = 1;
    send_beat(b);
    b = '0; b.look_toggle = 1; send_beat(b);
    b = '0; b.pointer_x = 12'hFFF; b.pointer_y = 12'hFFF; send_beat(b);
    b = '0; b.pointer_y = 12'h0; send_beat(b);
    b = '1; b.look_toggle = 0; send_beat(b);
    b = '0; b.move_back = 1; b.move_right = 1; b.move_left = 1; send_beat(b);
    b = '0; b.move_up = 1; b.move_down = 1; b.look_toggle = 1; send_beat(b);
    drain();
    apb_write(REG_SENS, 32'hFFFF);
    apb_write(REG_SPEED, 32'hFFFFFF);
    apb_write(REG_PPITCH, 32'h8000);
    apb_write(REG_PYAW, 32'h1FFFF);
    apb_write(REG_BEYOND | 4'd1, 32'hFFFFFFFF);
    b = '0; b.preset_key = 1; b.move_fwd = 1; send_beat(b);
    b = '0; b.look_toggle = 1; b.pointer_x = 12'h800; b.pointer_y = 12'h7FF;
    send_beat(b);
    for (int i = 0; i < 12; i++) begin
      b = '0; b.move_fwd = 1; b.move_right = 1; b.move_up = 1; send_beat(b);
    end
    b = '0; b.move_back = 1; b.move_left = 1; b.move_down = 1; send_beat(b);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      apb_write(REG_SENS, ph == 0 ? 0 : $urandom_range(65535));
      apb_write(REG_SPEED, ph == 1 ? 0 : $urandom_range(16777215));
      apb_write(REG_PPITCH, ph == 2 ? 32'h7FFF : $urandom_range(45568) - 22784);
      apb_write(REG_PYAW, ph == 3 ? 92159 : $urandom_range(131071));
      idle_pct = (ph == 4) ? 0 : 30;
      for (int i = 0; i < 255; i++) send_beat(rand_beat($urandom_range(9) < 7));
      drain();
    end
    idle_pct = 30;
    drain();
    $display("Sent %0d pointer/key beats over eight register settings; checked %0d poses.",
             sent, tracker.checked);
    if (tracker.errors == 0 && tracker.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #50000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
